FILE: rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared constants, round tables, command and status types and the SHA-256
// mixing functions used by the controller and the datapath.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int BLOCK_WORDS = BLOCK_BYTES / 4;
  localparam int FILL_W      = $clog2(BLOCK_BYTES);
  localparam int WORD_SEL_W  = $clog2(BLOCK_WORDS);
  localparam int LENGTH_AT   = 56;
  localparam int ROUNDS      = 64;
  localparam int ROUND_W     = $clog2(ROUNDS);
  localparam int COUNT_W     = 61;
  localparam int DIGEST_WORDS = 8;
  localparam int INDEX_W     = $clog2(DIGEST_WORDS);

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Operation codes of an input transaction.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [31:0] INIT_WORDS [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               wr_en;
    logic [FILL_W-1:0]  wr_pos;
    logic [7:0]         wr_byte;
    logic               wr_len;
    logic               count_inc;
    logic               count_clr;
    logic               start;
    logic               round_en;
    logic [ROUND_W-1:0] round;
    logic               fold;
    logic               emit;
  } sha256_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } sha256_sts_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

FILE: rtl/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Absorbs a message one byte per transaction and returns the eight digest
// words on a finish transaction.
// ----------------------------------------------------------------------------
// Flow: an absorb transaction is taken while idle; the byte that fills a block
//   starts the compression rounds and the chaining update, and the input is
//   not ready until both are done; the round unit does one round per cycle.
// A finish pads one byte per cycle to the length at byte 56 (first closing a
//   full block when a second is needed), runs the rounds, hands off once the
//   digest buffer is free; words leave one per cycle while out_ready is high.
// Reset is synchronous and clears all control state and restores the initial
//   chaining words; the block buffer needs no clearing pass.

module sha256_stream_hasher_unit
  import sha256_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Input channel: one transaction is one absorbed byte or one finish request.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [7:0]         message_byte,
  // Output channel: one transaction is one digest word.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        digest_word,
  output logic [INDEX_W-1:0] word_index,
  output logic               last_word
);

  // The controller decides what happens in each cycle; the datapath holds
  // every data register and reports back only whether the digest buffer is
  // still occupied. The digest buffer lets a new message start while the
  // previous digest is still being drained.
  sha256_cmd_t cmd;
  sha256_sts_t sts;

  sha256_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .message_byte (message_byte),
    .sts          (sts),
    .cmd          (cmd)
  );

  sha256_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule

FILE: rtl/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher controller
// Sequences byte loading, padding, the 64 compression rounds, the chaining
// update and the hand-off of the digest to the output buffer.
// ----------------------------------------------------------------------------
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  message_byte,
  input  sha256_sts_t sts,
  output sha256_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam logic [FILL_W-1:0]  FILL_LAST  = FILL_W'(BLOCK_BYTES - 1);
  localparam logic [FILL_W-1:0]  FILL_LEN   = FILL_W'(LENGTH_AT);
  localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

  logic [2:0]         state, state_next;
  logic [FILL_W-1:0]  fill, fill_next;
  logic [ROUND_W-1:0] round, round_next;
  logic               finishing, finishing_next;
  logic               pad_two, pad_two_next;

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    round_next     = round;
    finishing_next = finishing;
    pad_two_next   = pad_two;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_pos = fill;
          fill_next  = fill + 1'b1;
          if (operation == OP_ABSORB) begin
            cmd.wr_byte   = message_byte;
            cmd.count_inc = 1'b1;
            if (fill == FILL_LAST) begin
              cmd.start  = 1'b1;
              round_next = '0;
              state_next = ST_ROUND;
            end
          end else begin
            cmd.wr_byte    = PAD_BYTE;
            finishing_next = 1'b1;
            pad_two_next   = (fill >= FILL_LEN);
            state_next     = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (pad_two) begin
          // The pad marker left no room for the length: finish this block first.
          if (fill == '0) begin
            cmd.start  = 1'b1;
            round_next = '0;
            state_next = ST_ROUND;
          end else begin
            cmd.wr_en  = 1'b1;
            cmd.wr_pos = fill;
            fill_next  = fill + 1'b1;
          end
        end else if (fill == FILL_LEN) begin
          cmd.wr_len = 1'b1;
          cmd.start  = 1'b1;
          round_next = '0;
          state_next = ST_ROUND;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_pos = fill;
          fill_next  = fill + 1'b1;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        cmd.round    = round;
        round_next   = round + 1'b1;
        if (round == ROUND_LAST) begin
          state_next = (!finishing || pad_two) ? ST_FOLD : ST_EMIT;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (finishing) begin
          pad_two_next = 1'b0;
          state_next   = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit       = 1'b1;
          cmd.count_clr  = 1'b1;
          fill_next      = '0;
          finishing_next = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      round     <= '0;
      finishing <= 1'b0;
      pad_two   <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      round     <= round_next;
      finishing <= finishing_next;
      pad_two   <= pad_two_next;
    end
  end

endmodule

FILE: rtl/sha256_datapath.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher datapath
// Block buffer doubling as the message schedule window, one round unit,
// chaining words, byte counter and the digest output buffer.
// ----------------------------------------------------------------------------
module sha256_datapath
  import sha256_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  sha256_cmd_t         cmd,
  output sha256_sts_t         sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         digest_word,
  output logic [INDEX_W-1:0]  word_index,
  output logic                last_word
);

  logic [31:0]        blk   [BLOCK_WORDS];
  logic [31:0]        wv    [DIGEST_WORDS];
  logic [31:0]        chain [DIGEST_WORDS];
  logic [31:0]        obuf  [DIGEST_WORDS];
  logic [COUNT_W-1:0] count;
  logic [63:0]        bit_len;

  logic [WORD_SEL_W-1:0] wr_word;
  logic [1:0]            wr_lane;
  logic [31:0]           t1, t2, w_new, ch, maj;
  logic                  out_take;

  assign wr_word  = cmd.wr_pos[FILL_W-1:2];
  assign wr_lane  = cmd.wr_pos[1:0];
  assign bit_len  = {count, 3'b000};
  assign out_take = out_valid && out_ready;

  // One round: the window head is W[t]; W[t+16] enters at the tail.
  assign ch    = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign maj   = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t1    = wv[7] + big_sigma1(wv[4]) + ch + ROUND_K[cmd.round] + blk[0];
  assign t2    = big_sigma0(wv[0]) + maj;
  assign w_new = small_sigma1(blk[14]) + blk[9] + small_sigma0(blk[1]) + blk[0];

  always_ff @(posedge clk) begin
    if (cmd.round_en) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        blk[i] <= blk[i+1];
      end
      blk[BLOCK_WORDS-1] <= w_new;
    end else begin
      if (cmd.wr_en) begin
        blk[wr_word][{~wr_lane, 3'b000} +: 8] <= cmd.wr_byte;
      end
      if (cmd.wr_len) begin
        blk[BLOCK_WORDS-2] <= bit_len[63:32];
        blk[BLOCK_WORDS-1] <= bit_len[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        wv[i] <= chain[i];
      end
    end else if (cmd.round_en) begin
      wv[0] <= t1 + t2;
      wv[1] <= wv[0];
      wv[2] <= wv[1];
      wv[3] <= wv[2];
      wv[4] <= wv[3] + t1;
      wv[5] <= wv[4];
      wv[6] <= wv[5];
      wv[7] <= wv[6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain[i] <= INIT_WORDS[i];
      end
    end else if (cmd.fold) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain[i] <= chain[i] + wv[i];
      end
    end else if (cmd.emit) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain[i] <= INIT_WORDS[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.count_clr) begin
      count <= '0;
    end else if (cmd.count_inc) begin
      count <= count + 1'b1;
    end
  end

  // Digest buffer: words leave from the head, one per output transaction.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        obuf[i] <= chain[i] + wv[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
        obuf[i] <= obuf[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      word_index <= '0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_take && last_word) begin
        out_valid <= 1'b0;
      end
      if (out_take) begin
        word_index <= word_index + 1'b1;
      end
    end
  end

  assign digest_word  = obuf[0];
  assign last_word    = (word_index == INDEX_W'(DIGEST_WORDS - 1));
  assign sts.out_busy = out_valid;

endmodule

FILE: rtl/sha256_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher port checker
// Watches the ports of the hasher over time and flags sequencing errors of
// the digest stream and of the finish handling.
// ----------------------------------------------------------------------------
module sha256_checker
  import sha256_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               operation,
  input logic               out_valid,
  input logic               out_ready,
  input logic [31:0]        digest_word,
  input logic [INDEX_W-1:0] word_index,
  input logic               last_word
);

  // A stalled digest word holds its value and position.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest word changed while stalled");

  // Digest words come back to back in order once the first one is shown.
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=>
      out_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest words out of order");

  // The last flag marks the eighth word and nothing else.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  // The stream ends after the last word.
  a_stream_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> !out_valid)
    else $error("output still valid after last word");

  // A finish transaction blocks the input while padding starts.
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_FINISH) |=> !in_ready)
    else $error("input ready right after finish");

endmodule

bind sha256_stream_hasher_unit sha256_checker u_checker (.*);
